>>> sv/pdod_pkg.sv
package pdod_pkg;

    typedef enum logic [3:0] {
        FN_DELTA    = 4'd0,
        FN_DIFF222  = 4'd1,
        FN_L232BIAS = 4'd2,
        FN_L232     = 4'd3,
        FN_L454     = 4'd4,
        FN_L464     = 4'd5,
        FN_L676     = 4'd6,
        FN_L686     = 4'd7,
        FN_L787     = 4'd8,
        FN_DELTAA   = 4'd9,
        FN_ALPHA    = 4'd10,
        FN_L3433    = 4'd11,
        FN_L4645    = 4'd12,
        FN_L5654    = 4'd13,
        FN_L7777    = 4'd14
    } t_func;

    localparam logic [3:0] FN_NONE = 4'd15;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] prev_r;
        logic [7:0] prev_g;
        logic [7:0] prev_b;
        logic [7:0] prev_a;
        logic [7:0] ref_r;
        logic [7:0] ref_g;
        logic [7:0] ref_b;
    } t_op;

    typedef struct packed {
        logic [7:0] out_r;
        logic [7:0] out_g;
        logic [7:0] out_b;
        logic [7:0] out_a;
    } t_pix;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    localparam logic [4:0] TERN_LIMIT  = 5'd27;
    localparam logic [7:0] DELTA_ABASE = 8'd29;
    localparam logic [7:0] DELTAA_PBASE = 8'd27;
    localparam logic [7:0] DELTAA_NBASE = 8'd32;
    localparam logic [7:0] DIFF_BIAS   = 8'd2;

    // split a ternary code 0..26 into three digits and apply them around -1
    function automatic t_rgb tern(input t_rgb ref_pix, input logic [4:0] code);
        logic [1:0] d0;
        logic [1:0] d1;
        logic [1:0] d2;
        logic [4:0] rem;
        t_rgb       res;
        d2  = (code >= 5'd18) ? 2'd2 : ((code >= 5'd9) ? 2'd1 : 2'd0);
        rem = code - 5'd9 * {3'd0, d2};
        d1  = (rem >= 5'd6) ? 2'd2 : ((rem >= 5'd3) ? 2'd1 : 2'd0);
        d0  = 2'(rem - 5'd3 * {3'd0, d1});
        res.r = ref_pix.r + {6'd0, d0} - 8'd1;
        res.g = ref_pix.g + {6'd0, d1} - 8'd1;
        res.b = ref_pix.b + {6'd0, d2} - 8'd1;
        return res;
    endfunction

    function automatic t_rgb luma(input t_rgb ref_pix, input logic [7:0] g,
                                  input logic [7:0] gbias, input logic [7:0] fr,
                                  input logic [7:0] fb, input logic [7:0] cbias);
        logic [7:0] vg;
        t_rgb       res;
        vg    = g - gbias;
        res.r = ref_pix.r + vg - cbias + fr;
        res.g = ref_pix.g + vg;
        res.b = ref_pix.b + vg - cbias + fb;
        return res;
    endfunction

endpackage

>>> sv/pdod_op_if.sv
interface pdod_op_if;
    logic           valid;
    logic           ready;
    pdod_pkg::t_op  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/pdod_pix_if.sv
interface pdod_pix_if;
    logic           valid;
    logic           ready;
    pdod_pkg::t_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/pixel_delta_op_decoder_top.sv
// Pixel delta op decoder.
// i_op carries one op per transfer: the op kind, up to four op bytes, the
// previous pixel's RGBA and the reference pixel's RGB. o_pix returns one
// decoded RGBA pixel per op, in order, all channel arithmetic modulo 256.
// Both channels use valid/ready; a transfer happens when both are high.
// An op taken on i_op goes to the input register, then through the decode
// logic to the result register, which drives o_pix. Throughput: one op per
// cycle while o_pix takes pixels, set by the single decode stage.
// The input register and the result register each hold one item, so a new op
// is taken while a finished pixel waits. When o_pix stalls, the result
// register holds and the input register fills; with both full, i_op.ready
// drops until o_pix takes a pixel. An unused op kind passes the previous
// pixel through. Reset (i_rst_n low at a clock edge) empties both stages;
// items in flight are dropped.
module pixel_delta_op_decoder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pdod_op_if.sink           i_op,
    pdod_pix_if.source        o_pix
);

    logic           r_in_vld;
    pdod_pkg::t_op  r_in;
    logic           r_out_vld;
    pdod_pkg::t_pix r_out;
    logic           out_rdy;
    pdod_pkg::t_pix n_out;
    pdod_pkg::t_rgb ref_pix;
    pdod_pkg::t_rgb lu;
    pdod_pkg::t_rgb tn;
    logic [4:0]     x5;

    assign out_rdy    = !r_out_vld || o_pix.ready;
    assign i_op.ready = !r_in_vld || out_rdy;
    assign o_pix.valid = r_out_vld;
    assign o_pix.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_op.ready) begin
                r_in_vld <= i_op.valid;
            end
            if (out_rdy) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.ready && i_op.valid) begin
            r_in <= i_op.data;
        end
        if (out_rdy && r_in_vld) begin
            r_out <= n_out;
        end
    end

    assign ref_pix = '{r: r_in.ref_r, g: r_in.ref_g, b: r_in.ref_b};
    assign x5      = r_in.byte0[4:0];
    assign tn      = pdod_pkg::tern(ref_pix, x5);

    always_comb begin
        n_out.out_r = r_in.prev_r;
        n_out.out_g = r_in.prev_g;
        n_out.out_b = r_in.prev_b;
        n_out.out_a = r_in.prev_a;
        lu          = ref_pix;
        case (pdod_pkg::t_func'(r_in.func))
            pdod_pkg::FN_DELTA: begin
                if (x5 < pdod_pkg::TERN_LIMIT) begin
                    lu = tn;
                end else begin
                    n_out.out_a = r_in.prev_a + {3'd0, x5} - pdod_pkg::DELTA_ABASE;
                end
            end
            pdod_pkg::FN_DIFF222: begin
                lu.r = r_in.ref_r + {6'd0, r_in.byte0[5:4]} - pdod_pkg::DIFF_BIAS;
                lu.g = r_in.ref_g + {6'd0, r_in.byte0[3:2]} - pdod_pkg::DIFF_BIAS;
                lu.b = r_in.ref_b + {6'd0, r_in.byte0[1:0]} - pdod_pkg::DIFF_BIAS;
            end
            pdod_pkg::FN_L232BIAS: begin
                lu = pdod_pkg::luma(ref_pix, {5'd0, r_in.byte0[6:4]}, 8'd4,
                                    {6'd0, r_in.byte0[3:2]}, {6'd0, r_in.byte0[1:0]},
                                    r_in.byte0[6] ? 8'd2 : 8'd1);
            end
            pdod_pkg::FN_L232: begin
                lu = pdod_pkg::luma(ref_pix, {5'd0, r_in.byte0[6:4]}, 8'd4,
                                    {6'd0, r_in.byte0[3:2]}, {6'd0, r_in.byte0[1:0]},
                                    8'd2);
            end
            pdod_pkg::FN_L454: begin
                lu = pdod_pkg::luma(ref_pix, {3'd0, r_in.byte0[4:0]}, 8'd16,
                                    {4'd0, r_in.byte1[7:4]}, {4'd0, r_in.byte1[3:0]},
                                    8'd8);
            end
            pdod_pkg::FN_L464: begin
                lu = pdod_pkg::luma(ref_pix, {2'd0, r_in.byte0[5:0]}, 8'd32,
                                    {4'd0, r_in.byte1[7:4]}, {4'd0, r_in.byte1[3:0]},
                                    8'd8);
            end
            pdod_pkg::FN_L676: begin
                lu = pdod_pkg::luma(ref_pix, {1'b0, r_in.byte0[2:0], r_in.byte1[7:4]},
                                    8'd64, {2'd0, r_in.byte2[5:0]},
                                    {2'd0, r_in.byte1[3:0], r_in.byte2[7:6]}, 8'd32);
            end
            pdod_pkg::FN_L686: begin
                lu = pdod_pkg::luma(ref_pix, r_in.byte2, 8'd128,
                                    {2'd0, r_in.byte0[3:0], r_in.byte1[7:6]},
                                    {2'd0, r_in.byte1[5:0]}, 8'd32);
            end
            pdod_pkg::FN_L787: begin
                lu = pdod_pkg::luma(ref_pix, r_in.byte1, 8'd128,
                                    {1'b0, r_in.byte0[5:0], r_in.byte2[7]},
                                    {1'b0, r_in.byte2[6:0]}, 8'd64);
            end
            pdod_pkg::FN_DELTAA: begin
                if (x5 >= pdod_pkg::TERN_LIMIT) begin
                    n_out.out_a = r_in.prev_a + {3'd0, x5}
                                  - (r_in.byte0[5] ? pdod_pkg::DELTAA_PBASE
                                                   : pdod_pkg::DELTAA_NBASE);
                end else begin
                    n_out.out_a = r_in.byte0[5] ? r_in.prev_a + 8'd1 : r_in.prev_a - 8'd1;
                    lu          = tn;
                end
            end
            pdod_pkg::FN_ALPHA: begin
                n_out.out_a = r_in.byte1;
            end
            pdod_pkg::FN_L3433: begin
                lu = pdod_pkg::luma(ref_pix, {4'd0, r_in.byte1[3:0]}, 8'd8,
                                    {5'd0, r_in.byte0[4:2]},
                                    {5'd0, r_in.byte0[1:0], r_in.byte1[7]}, 8'd4);
                n_out.out_a = r_in.prev_a + {5'd0, r_in.byte1[6:4]} - 8'd4;
            end
            pdod_pkg::FN_L4645: begin
                lu = pdod_pkg::luma(ref_pix, {2'd0, r_in.byte0[2:0], r_in.byte1[7:5]},
                                    8'd32, {4'd0, r_in.byte2[7:4]},
                                    {4'd0, r_in.byte2[3:0]}, 8'd8);
                n_out.out_a = r_in.prev_a + {3'd0, r_in.byte1[4:0]} - 8'd16;
            end
            pdod_pkg::FN_L5654: begin
                lu = pdod_pkg::luma(ref_pix, {2'd0, r_in.byte2[5:0]}, 8'd32,
                                    {3'd0, r_in.byte1[7:3]},
                                    {3'd0, r_in.byte1[2:0], r_in.byte2[7:6]}, 8'd16);
                n_out.out_a = r_in.prev_a + {4'd0, r_in.byte0[3:0]} - 8'd8;
            end
            pdod_pkg::FN_L7777: begin
                lu = pdod_pkg::luma(ref_pix, {1'b0, r_in.byte1[4:0], r_in.byte2[7:6]},
                                    8'd64, {1'b0, r_in.byte0[3:0], r_in.byte1[7:5]},
                                    {1'b0, r_in.byte2[5:0], r_in.byte3[7]}, 8'd64);
                n_out.out_a = r_in.prev_a + {1'b0, r_in.byte3[6:0]} - 8'd64;
            end
            default: begin
                lu = ref_pix;
            end
        endcase
        if ((pdod_pkg::t_func'(r_in.func) == pdod_pkg::FN_ALPHA)
            || (r_in.func == pdod_pkg::FN_NONE)
            || ((pdod_pkg::t_func'(r_in.func) == pdod_pkg::FN_DELTA)
                && (x5 >= pdod_pkg::TERN_LIMIT))
            || ((pdod_pkg::t_func'(r_in.func) == pdod_pkg::FN_DELTAA)
                && (x5 >= pdod_pkg::TERN_LIMIT))) begin
            n_out.out_r = r_in.prev_r;
            n_out.out_g = r_in.prev_g;
            n_out.out_b = r_in.prev_b;
        end else begin
            n_out.out_r = lu.r;
            n_out.out_g = lu.g;
            n_out.out_b = lu.b;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_pix.valid)
        else $error("result valid after reset");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && out_rdy |=> o_pix.valid && (o_pix.data == $past(n_out)))
        else $error("decoded pixel not advanced to result register");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !o_pix.ready |-> !i_op.ready)
        else $error("op taken while both stages full");

    a_alpha_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && out_rdy && (pdod_pkg::t_func'(r_in.func) == pdod_pkg::FN_ALPHA)
        |=> (o_pix.data.out_a == $past(r_in.byte1))
            && (o_pix.data.out_r == $past(r_in.prev_r)))
        else $error("alpha op result wrong");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_pix.ready |=> r_in_vld || !$past(r_in_vld))
        else $error("pending op lost under stall");

endmodule
